// File: rtl/ptsf_pkg.sv
// Package for the PWM temperature sensor filter.
// Holds conversion constants, register indexes, reset values and shared types.
// No dependencies.
package ptsf_pkg;

    localparam int COUNT_BITS_DEF = 15;

    localparam int HISTORY_DEPTH = 4;
    localparam int HIST_IDX_W    = $clog2(HISTORY_DEPTH);
    localparam int TEMP_W        = 16;
    localparam int SUM_W         = TEMP_W + HIST_IDX_W;

    localparam int SLOPE_W   = 10;
    localparam int K_CNT_W   = $clog2(SLOPE_W);
    localparam logic [SLOPE_W-1:0] CONV_SLOPE  = 10'd751;
    localparam logic [TEMP_W-1:0]  CONV_OFFSET = 16'd421;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TEMP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_WINDOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_READINGS = 2'd2;

    localparam logic [7:0] RST_DEFAULT_TEMP     = 8'd25;
    localparam logic [7:0] RST_ACCEPT_WINDOW    = 8'd10;
    localparam logic [3:0] RST_STARTUP_READINGS = 4'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_AVG,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic avg_en;
        logic commit;
    } t_hist_ctrl;

    typedef struct packed {
        logic                     startup;
        logic                     accept;
        logic signed [TEMP_W-1:0] avg;
    } t_hist_status;

endpackage

// File: rtl/ptsf_mul.sv
// Serial multiplier: capture count times the conversion slope, one slope bit per cycle.
// Depends on ptsf_pkg.
module ptsf_mul #(
    parameter int COUNT_BITS = ptsf_pkg::COUNT_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    input  logic [COUNT_BITS-1:0]                    i_mcand,
    output logic                                     o_done,
    output logic [COUNT_BITS+ptsf_pkg::SLOPE_W-1:0]  o_product
);
    import ptsf_pkg::*;

    localparam int PROD_W = COUNT_BITS + SLOPE_W;

    logic [PROD_W-1:0]  r_acc;
    logic [PROD_W-1:0]  r_mcand;
    logic [K_CNT_W-1:0] r_k;
    logic               r_busy;
    logic               r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_k <= r_k + 1'b1;
                if (r_k == K_CNT_W'(SLOPE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc   <= '0;
            r_mcand <= PROD_W'(i_mcand);
        end else if (r_busy) begin
            if (CONV_SLOPE[r_k]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand <= {r_mcand[PROD_W-2:0], 1'b0};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// File: rtl/ptsf_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ptsf_pkg.
module ptsf_div #(
    parameter int COUNT_BITS = ptsf_pkg::COUNT_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    input  logic [COUNT_BITS+ptsf_pkg::SLOPE_W-1:0]  i_dividend,
    input  logic [COUNT_BITS-1:0]                    i_divisor,
    output logic                                     o_done,
    output logic [COUNT_BITS+ptsf_pkg::SLOPE_W-1:0]  o_quotient
);
    import ptsf_pkg::*;

    localparam int PROD_W = COUNT_BITS + SLOPE_W;
    localparam int REM_W  = COUNT_BITS + 1;
    localparam int CNT_W  = $clog2(PROD_W);

    logic [REM_W-1:0]      r_rem;
    logic [PROD_W-1:0]     r_quo;
    logic [COUNT_BITS-1:0] r_div;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [REM_W-1:0] shifted;
    logic [REM_W:0]   diff;
    logic             ge;

    always_comb begin
        shifted = {r_rem[REM_W-2:0], r_quo[PROD_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_div};
        ge      = !diff[REM_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(PROD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[REM_W-1:0] : shifted;
            r_quo <= {r_quo[PROD_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: rtl/ptsf_hist.sv
// History ring, startup counter, ring average and acceptance window check.
// Depends on ptsf_pkg.
module ptsf_hist (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ptsf_pkg::t_hist_ctrl                i_ctrl,
    input  logic signed [ptsf_pkg::TEMP_W-1:0]  i_raw,
    input  logic [7:0]                          i_window,
    input  logic [3:0]                          i_startup_readings,
    output ptsf_pkg::t_hist_status              o_status
);
    import ptsf_pkg::*;

    logic signed [TEMP_W-1:0] r_hist [HISTORY_DEPTH];
    logic [HIST_IDX_W-1:0]    r_idx;
    logic [3:0]               r_count;
    logic signed [TEMP_W-1:0] r_avg;

    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sum_adj;
    logic signed [SUM_W-1:0]  raw_x;
    logic signed [SUM_W-1:0]  avg_x;
    logic signed [SUM_W-1:0]  win_x;
    logic                     startup;
    logic                     in_window;
    logic                     accept;

    always_comb begin
        sum = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            sum = sum + SUM_W'(r_hist[i]);
        end
        sum_adj   = sum[SUM_W-1] ? sum + SUM_W'(HISTORY_DEPTH - 1) : sum;
        raw_x     = SUM_W'(i_raw);
        avg_x     = SUM_W'(r_avg);
        win_x     = SUM_W'(i_window);
        startup   = r_count < i_startup_readings;
        in_window = (raw_x < avg_x + win_x) && (raw_x > avg_x - win_x);
        accept    = startup || in_window;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_count <= '0;
        end else if (i_ctrl.commit) begin
            if (accept) begin
                r_idx <= r_idx + 1'b1;
            end
            if (startup) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.commit && accept) begin
            r_hist[r_idx] <= i_raw;
        end
        if (i_ctrl.avg_en) begin
            r_avg <= TEMP_W'(sum_adj >>> HIST_IDX_W);
        end
    end

    assign o_status.startup = startup;
    assign o_status.accept  = accept;
    assign o_status.avg     = r_avg;

endmodule

// File: rtl/pwm_temp_sensor_filter.sv
// PWM temperature sensor filter, top level. Uses ptsf_pkg, ptsf_mul, ptsf_div, ptsf_hist.
// Low-time beat: stored as the divisor, no result. High-time beat: serial multiply, bit-serial
// divide, then average and decide steps, after which the result is registered on the output;
// the multiply and divide are skipped when the stored low time is zero.
// One item at a time; a new beat is taken while a finished result waits on the output.
// Synchronous active-low reset clears control state and restores register defaults.
module pwm_temp_sensor_filter #(
    parameter int COUNT_BITS = ptsf_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [COUNT_BITS-1:0]               i_capture_count,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [ptsf_pkg::TEMP_W-1:0]  o_temperature_c,
    output logic signed [ptsf_pkg::TEMP_W-1:0]  o_raw_reading,
    output logic                                o_reading_accepted,
    output logic                                o_in_startup,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ptsf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [7:0]                          i_cfg_data
);
    import ptsf_pkg::*;

    localparam int PROD_W = COUNT_BITS + SLOPE_W;

    t_state                   r_state;
    t_state                   n_state;
    logic [7:0]               r_default_temp;
    logic [7:0]               r_accept_window;
    logic [3:0]               r_startup_readings;
    logic                     r_expect_high;
    logic [COUNT_BITS-1:0]    r_low;
    logic signed [TEMP_W-1:0] r_raw;
    logic                     r_out_valid;
    logic signed [TEMP_W-1:0] r_temp_out;
    logic signed [TEMP_W-1:0] r_raw_out;
    logic                     r_acc_out;
    logic                     r_start_out;

    logic                     in_beat;
    logic                     mul_start;
    logic                     mul_done;
    logic [PROD_W-1:0]        product;
    logic                     div_done;
    logic [PROD_W-1:0]        quotient;
    logic                     out_load;
    logic signed [TEMP_W-1:0] default_x;
    t_hist_ctrl               hist_ctrl;
    t_hist_status             hist_status;

    assign default_x = {{(TEMP_W-8){r_default_temp[7]}}, r_default_temp};
    assign in_beat   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        mul_start        = 1'b0;
        out_load         = 1'b0;
        hist_ctrl.avg_en = 1'b0;
        hist_ctrl.commit = 1'b0;
        o_in_stall       = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid && r_expect_high) begin
                    if (r_low == '0) begin
                        n_state = S_AVG;
                    end else begin
                        mul_start = 1'b1;
                        n_state   = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_AVG;
                end
            end
            S_AVG: begin
                hist_ctrl.avg_en = 1'b1;
                n_state          = S_DECIDE;
            end
            S_DECIDE: begin
                if (!(r_out_valid && i_out_stall)) begin
                    hist_ctrl.commit = 1'b1;
                    out_load         = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_temp     <= RST_DEFAULT_TEMP;
            r_accept_window    <= RST_ACCEPT_WINDOW;
            r_startup_readings <= RST_STARTUP_READINGS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEFAULT_TEMP:     r_default_temp     <= i_cfg_data;
                CFG_ACCEPT_WINDOW:    r_accept_window    <= i_cfg_data;
                CFG_STARTUP_READINGS: r_startup_readings <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_high <= 1'b0;
            r_low         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_beat) begin
                r_expect_high <= !r_expect_high;
                if (!r_expect_high) begin
                    r_low <= i_capture_count;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat && r_expect_high && r_low == '0) begin
            r_raw <= default_x;
        end else if (r_state == S_DIV && div_done) begin
            r_raw <= CONV_OFFSET - quotient[TEMP_W-1:0];
        end
        if (out_load) begin
            r_temp_out  <= hist_status.startup ? default_x : hist_status.avg;
            r_raw_out   <= r_raw;
            r_acc_out   <= hist_status.accept;
            r_start_out <= hist_status.startup;
        end
    end

    ptsf_mul #(
        .COUNT_BITS (COUNT_BITS)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (i_capture_count),
        .o_done    (mul_done),
        .o_product (product)
    );

    ptsf_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mul_done),
        .i_dividend (product),
        .i_divisor  (r_low),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    ptsf_hist u_hist (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctrl             (hist_ctrl),
        .i_raw              (r_raw),
        .i_window           (r_accept_window),
        .i_startup_readings (r_startup_readings),
        .o_status           (hist_status)
    );

    assign o_cfg_ready        = 1'b1;
    assign o_out_valid        = r_out_valid;
    assign o_temperature_c    = r_temp_out;
    assign o_raw_reading      = r_raw_out;
    assign o_reading_accepted = r_acc_out;
    assign o_in_startup       = r_start_out;

    a_load_gives_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_out_valid)
        else $error("result load did not raise output valid");

    a_rise_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_DECIDE)
        else $error("output valid rose outside decide step");

    a_startup_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_in_startup |-> o_reading_accepted)
        else $error("startup reading not stored");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> !(r_out_valid && i_out_stall))
        else $error("pending result overwritten");

    a_div_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside divide step");

endmodule

// File: tb/pwm_temp_sensor_filter_tb.sv
// Self-checking testbench for pwm_temp_sensor_filter: capture beats in, filtered readings out.
// A scoreboard class predicts each reading from its own copy of the filter state.
// Depends on ptsf_pkg and the pwm_temp_sensor_filter RTL.
module pwm_temp_sensor_filter_tb;
    import ptsf_pkg::*;

    localparam int CB = COUNT_BITS_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

    class temp_scoreboard;
        typedef struct packed {
            logic signed [TEMP_W-1:0] temp;
            logic signed [TEMP_W-1:0] raw;
            logic                     accepted;
            logic                     startup;
        } reading_t;

        logic signed [7:0]        default_temp;
        logic [7:0]               accept_window;
        logic [3:0]               startup_readings;
        bit                       expect_high;
        logic [CB-1:0]            low_time;
        logic signed [TEMP_W-1:0] history [HISTORY_DEPTH];
        logic [HIST_IDX_W-1:0]    hist_idx;
        logic [3:0]               startup_count;
        reading_t                 pending_q [$];
        int mismatches, beats, results, taken, startups, settings;

        function new();
            default_temp     = RST_DEFAULT_TEMP;
            accept_window    = RST_ACCEPT_WINDOW;
            startup_readings = RST_STARTUP_READINGS;
            expect_high      = 0;
            low_time         = '0;
            hist_idx         = '0;
            startup_count    = '0;
            foreach (history[i]) history[i] = '0;
            mismatches = 0; beats = 0; results = 0; taken = 0; startups = 0; settings = 1;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] d);
            case (idx)
                CFG_DEFAULT_TEMP:     default_temp = d;
                CFG_ACCEPT_WINDOW:    accept_window = d;
                CFG_STARTUP_READINGS: startup_readings = d[3:0];
                default: ;
            endcase
        endfunction

        function int history_avg();
            int sum;
            sum = 0;
            foreach (history[i]) sum += history[i];
            return sum / HISTORY_DEPTH;
        endfunction

        function void push_history(logic signed [TEMP_W-1:0] v);
            history[hist_idx] = v;
            hist_idx++;
        endfunction

        function void note_capture(logic [CB-1:0] cap);
            logic [31:0]              quot;
            logic signed [TEMP_W-1:0] raw;
            reading_t                 r;
            int                       avg, rv, w;
            beats++;
            if (!expect_high) begin
                low_time = cap;
                expect_high = 1;
                return;
            end
            expect_high = 0;
            if (low_time == 0) begin
                raw = default_temp;
            end else begin
                quot = (32'(CONV_SLOPE) * 32'(cap)) / 32'(low_time);
                raw = 16'(32'(CONV_OFFSET) - quot);
            end
            if (startup_count < startup_readings) begin
                startup_count++;
                push_history(raw);
                r.temp = default_temp;
                r.accepted = 1'b1;
                r.startup = 1'b1;
            end else begin
                avg = history_avg();
                rv = raw;
                w = int'(accept_window);
                r.accepted = (rv < avg + w) && (rv > avg - w);
                if (r.accepted) push_history(raw);
                r.temp = avg[TEMP_W-1:0];
                r.startup = 1'b0;
            end
            r.raw = raw;
            pending_q.push_back(r);
        endfunction

        function void check_reading(logic signed [TEMP_W-1:0] temp, logic signed [TEMP_W-1:0] raw,
                                    logic accepted, logic startup);
            reading_t e;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: reading with none pending: temp=%0d raw=%0d acc=%0b st=%0b",
                             temp, raw, accepted, startup);
                return;
            end
            e = pending_q.pop_front();
            results++;
            if (e.accepted) taken++;
            if (e.startup) startups++;
            if (e.temp !== temp || e.raw !== raw || e.accepted !== accepted
                    || e.startup !== startup) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: reading %0d: exp temp=%0d raw=%0d acc=%0b st=%0b, got temp=%0d raw=%0d acc=%0b st=%0b",
                             results, e.temp, e.raw, e.accepted, e.startup,
                             temp, raw, accepted, startup);
            end
        endfunction
    endclass

    typedef enum {PK_TARGET, PK_ZERO, PK_NOISE} pair_kind_t;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [CB-1:0]            i_capture_count;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [TEMP_W-1:0] o_temperature_c;
    logic signed [TEMP_W-1:0] o_raw_reading;
    logic                     o_reading_accepted;
    logic                     o_in_startup;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [7:0]               i_cfg_data;

    temp_scoreboard sb;
    pair_kind_t     pair_kind;

    logic [CB-1:0] dir_low  [10] = '{0, 0, 1, CNT_MAX, CNT_MAX, 1, 751, 751, 751, 751};
    logic [CB-1:0] dir_high [10] = '{0, CNT_MAX, CNT_MAX, 0, CNT_MAX, 1, 421, 400, 396, 396};

    pwm_temp_sensor_filter #(.COUNT_BITS(CB)) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_capture_count    (i_capture_count),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_temperature_c    (o_temperature_c),
        .o_raw_reading      (o_raw_reading),
        .o_reading_accepted (o_reading_accepted),
        .o_in_startup       (o_in_startup),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("pwm_temp_sensor_filter test failed");
        $finish;
    end

    // receiver stall pattern: free-running, none / random / long runs
    initial begin
        int  mode, span, run;
        logic level;
        i_out_stall = 1'b0;
        run = 0;
        level = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(50, 300);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 2) == 0);
                    default: begin
                        if (run == 0) begin
                            run = $urandom_range(1, 20);
                            level = ~level;
                        end
                        run--;
                        i_out_stall <= level;
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_reading(o_temperature_c, o_raw_reading, o_reading_accepted, o_in_startup);
    end

    // entered and left at a falling edge; valid is left high for a following beat
    task automatic send_beat(logic [CB-1:0] v);
        i_in_valid <= 1'b1;
        i_capture_count <= v;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_capture(v);
        @(negedge i_clk);
    endtask

    task automatic pause(int n);
        i_in_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        pause(1);
        while (sb.pending_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, logic [7:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, d);
        @(negedge i_clk);
    endtask

    // low-time beats leave no result, so allow the block to settle after the drain
    task automatic set_regs(logic [7:0] dt, logic [7:0] aw, logic [7:0] sr);
        drain();
        repeat (50) @(negedge i_clk);
        cfg_beat(CFG_DEFAULT_TEMP, dt);
        cfg_beat(CFG_ACCEPT_WINDOW, aw);
        cfg_beat(CFG_STARTUP_READINGS, sr);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        sb.settings++;
    endtask

    function automatic logic [CB-1:0] high_for(int t, logic [CB-1:0] lo);
        int h;
        if (t > 421) return '0;
        h = ((421 - t) * int'(lo)) / 751;
        return (h > int'(CNT_MAX)) ? CNT_MAX : CB'(h);
    endfunction

    function automatic logic [CB-1:0] next_capture();
        int pick, w, t;
        if (!sb.expect_high) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                pair_kind = PK_TARGET;
                return $urandom_range(0, 1) ? CB'(751) : CB'($urandom_range(751, 32767));
            end else if (pick < 80) begin
                pair_kind = PK_ZERO;
                return '0;
            end
            pair_kind = PK_NOISE;
        end else if (pair_kind == PK_TARGET && sb.low_time != 0) begin
            w = int'(sb.accept_window);
            t = sb.history_avg() + int'($urandom_range(0, 2 * w + 6)) - (w + 3);
            return high_for(t, sb.low_time);
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return CNT_MAX;
        return CB'($urandom_range(0, 32767));
    endfunction

    task automatic run_random(int n);
        int  sent, burst, k;
        bit  held;
        sent = 0;
        held = 0;
        while (sent < n) begin
            if ($urandom_range(0, 3) == 0) burst = $urandom_range(20, 80);
            else burst = $urandom_range(1, 12);
            for (k = 0; k < burst && sent < n; k++) begin
                send_beat(next_capture());
                sent++;
            end
            if (!held && sent >= n / 2) begin
                drain();
                held = 1;
            end
            pause($urandom_range(1, 15));
        end
    endtask

    initial begin
        int i, w;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_capture_count = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        sb = new();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // startup readings: zero low time, extremes, wrapped conversion
        for (i = 0; i < 10; i++) begin
            send_beat(dir_low[i]);
            send_beat(dir_high[i]);
        end
        // first normal readings: just inside and on the window edge
        w = int'(sb.accept_window);
        send_beat(CB'(751));
        send_beat(high_for(sb.history_avg() + w - 1, CB'(751)));
        send_beat(CB'(751));
        send_beat(high_for(sb.history_avg() + w, CB'(751)));
        pause(1);
        run_random(180);

        set_regs(8'h80, 8'd0, 8'd15);
        run_random(230);
        set_regs(8'h7F, 8'd255, 8'd0);
        run_random(230);
        set_regs(8'd0, 8'd1, 8'hF3);
        run_random(230);
        drain();
        repeat (50) @(negedge i_clk);
        cfg_beat(CFG_UNUSED, 8'($urandom));
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        for (i = 0; i < 3; i++) begin
            set_regs(8'($urandom), 8'($urandom_range(3, 60)), 8'($urandom));
            run_random(230);
        end

        drain();
        repeat (60) @(posedge i_clk);
        $display("Covered %0d capture beats, %0d readings (%0d startup, %0d stored) over %0d settings.",
                 sb.beats, sb.results, sb.startups, sb.taken, sb.settings);
        $display("Mismatches: %0d, readings still pending: %0d",
                 sb.mismatches, sb.pending_q.size());
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("pwm_temp_sensor_filter test passed");
        end else begin
            $display("pwm_temp_sensor_filter test failed");
        end
        $finish;
    end

endmodule

// File: pwm_temp_sensor_filter.f
rtl/ptsf_pkg.sv
rtl/ptsf_mul.sv
rtl/ptsf_div.sv
rtl/ptsf_hist.sv
rtl/pwm_temp_sensor_filter.sv
tb/pwm_temp_sensor_filter_tb.sv
